/* rtl/assert_macros.svh */
// assertion macros used by the rtl of the accumulator cpu core
// depends on clk_i and rst_ni being visible where the macros are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising edge outside reset
`define ACPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define ACPU_ASSERT_IMPL(lbl, ante, cons, msg) \
  `ACPU_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define ACPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  `ACPU_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* rtl/acpu_pkg.sv */
// types, codes and constants of the accumulator cpu core
// no dependencies
package acpu_pkg;

  localparam int MEM_WORDS     = 1024;
  localparam int ADDR_BITS     = $clog2(MEM_WORDS);
  localparam int WORD_BITS     = 32;
  localparam int OPC_BITS      = 8;
  localparam int STEP_BITS     = 24;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  localparam logic [ADDR_BITS-1:0] PROG_END_RST    = ADDR_BITS'(0);
  localparam logic [ADDR_BITS-1:0] STACK_START_RST = ADDR_BITS'(2);
  localparam logic [STEP_BITS-1:0] STEP_LIMIT_RST  = STEP_BITS'(10000000);
  localparam logic [ADDR_BITS-1:0] PC_START        = ADDR_BITS'(1);

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_EXEC  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [OPC_BITS-1:0] {
    OPC_LDC  = 8'd0,
    OPC_ADC  = 8'd1,
    OPC_LDL  = 8'd2,
    OPC_STL  = 8'd3,
    OPC_LDNL = 8'd4,
    OPC_STNL = 8'd5,
    OPC_ADD  = 8'd6,
    OPC_SUB  = 8'd7,
    OPC_SHL  = 8'd8,
    OPC_SHR  = 8'd9,
    OPC_ADJ  = 8'd10,
    OPC_A2SP = 8'd11,
    OPC_SP2A = 8'd12,
    OPC_CALL = 8'd13,
    OPC_RET  = 8'd14,
    OPC_BRZ  = 8'd15,
    OPC_BRLZ = 8'd16,
    OPC_BR   = 8'd17,
    OPC_HALT = 8'd18
  } opc_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_HALTED      = 3'd1,
    ST_INVALID     = 3'd2,
    ST_PAST_END    = 3'd3,
    ST_STEP_LIMIT  = 3'd4,
    ST_NOT_RUNNING = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PROGRAM_END = 2'd0,
    CFG_STACK_START = 2'd1,
    CFG_STEP_LIMIT  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_FETCH,
    FSM_LOAD
  } fsm_e;

  typedef struct packed {
    cmd_e                   op;
    logic [ADDR_BITS-1:0]   address;
    logic signed [31:0]     data;
  } acpu_in_t;

  typedef struct packed {
    status_e                status;
    logic [ADDR_BITS-1:0]   pc_out;
    logic signed [31:0]     acc_a;
    logic signed [31:0]     acc_b;
    logic [ADDR_BITS-1:0]   sp_out;
  } acpu_out_t;

endpackage

/* rtl/accumulator_cpu_core_top.sv */
// top level of the accumulator cpu core: sequencer, registers and main memory
// depends on acpu_pkg, acpu_ram and assert_macros.svh
`include "assert_macros.svh"

// After reset the core sweeps its 1024-word memory to zero, one word a cycle,
// and holds busy_o high during the sweep; configuration writes are taken
// at any time. A write, start or no-op word, and an execute word while the core
// is stopped or past the program end, finish in the accept cycle: busy_o stays
// low and the result strobe follows in the next cycle. An executed instruction
// keeps busy_o high through the fetch state (fetch read of the memory port),
// and also through the load state for ldl and ldnl (second read for the data
// word), and its result word appears on res_o with res_valid_o for exactly one
// cycle right after that; the receiver cannot stall it, so it must take every
// strobed word. Memory, pc and sp addresses wrap modulo 1024.
module accumulator_cpu_core_top
  import acpu_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  acpu_in_t                 item_i,
  output logic                     busy_o,
  output logic                     res_valid_o,
  output acpu_out_t                res_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i
);

  fsm_e                   state_q, state_d;
  logic [ADDR_BITS-1:0]   clr_q, clr_d;
  logic [ADDR_BITS-1:0]   pc_q, pc_d, sp_q, sp_d;
  logic [WORD_BITS-1:0]   a_q, a_d, b_q, b_d;
  logic [STEP_BITS-1:0]   steps_q, steps_d;
  logic                   run_q, run_d;
  status_e                stat_q, stat_d;
  logic [ADDR_BITS-1:0]   prog_end_q, stack_start_q;
  logic [STEP_BITS-1:0]   step_limit_q;
  acpu_out_t              res_q, res_d;
  logic                   res_vld_q, res_vld_d;

  logic                   mem_we, mem_re;
  logic [ADDR_BITS-1:0]   mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0]   mem_wdata, mem_rdata;

  logic [WORD_BITS-1:0]   instr, operand;
  logic [OPC_BITS-1:0]    opc;
  logic [ADDR_BITS-1:0]   off, pc_rel, sp_rel, a_rel, pc_nx;
  logic                   shamt_big, done, is_load, is_stop;
  status_e                status;

  acpu_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MEM_WORDS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign instr     = mem_rdata;
  assign opc       = instr[OPC_BITS-1:0];
  assign operand   = {{OPC_BITS{instr[WORD_BITS-1]}}, instr[WORD_BITS-1:OPC_BITS]};
  assign off       = instr[OPC_BITS +: ADDR_BITS];
  assign pc_rel    = pc_q + off;
  assign sp_rel    = sp_q + off;
  assign a_rel     = a_q[ADDR_BITS-1:0] + off;
  assign shamt_big = |a_q[WORD_BITS-1:$clog2(WORD_BITS)];

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    pc_d      = pc_q;
    sp_d      = sp_q;
    a_d       = a_q;
    b_d       = b_q;
    steps_d   = steps_q;
    run_d     = run_q;
    stat_d    = stat_q;
    res_d     = res_q;
    res_vld_d = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = pc_q;
    pc_nx     = pc_q + ADDR_BITS'(1);
    done      = 1'b0;
    is_load   = 1'b0;
    is_stop   = 1'b0;
    status    = ST_OK;

    unique case (state_q)
      FSM_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + ADDR_BITS'(1);
        if (clr_q == ADDR_BITS'(MEM_WORDS - 1)) begin
          state_d = FSM_IDLE;
        end
      end

      FSM_IDLE: begin
        if (start_i) begin
          unique case (item_i.op)
            CMD_WRITE: begin
              mem_we    = 1'b1;
              mem_waddr = item_i.address;
              mem_wdata = item_i.data;
              done      = 1'b1;
            end
            CMD_START: begin
              pc_d    = PC_START;
              sp_d    = stack_start_q;
              a_d     = '0;
              b_d     = '0;
              steps_d = '0;
              run_d   = 1'b1;
              done    = 1'b1;
            end
            CMD_EXEC: begin
              if (!run_q) begin
                status = ST_NOT_RUNNING;
                done   = 1'b1;
              end else if (pc_q > prog_end_q) begin
                run_d  = 1'b0;
                status = ST_PAST_END;
                done   = 1'b1;
              end else begin
                steps_d   = steps_q + STEP_BITS'(1);
                mem_re    = 1'b1;
                mem_raddr = pc_q;
                state_d   = FSM_FETCH;
              end
            end
            CMD_NONE: begin
              done = 1'b1;
            end
          endcase
        end
      end

      FSM_FETCH: begin
        unique case (opc)
          OPC_LDC: begin
            b_d = a_q;
            a_d = operand;
          end
          OPC_ADC: a_d = a_q + operand;
          OPC_LDL: begin
            b_d       = a_q;
            mem_re    = 1'b1;
            mem_raddr = sp_rel;
            is_load   = 1'b1;
          end
          OPC_STL: begin
            mem_we    = 1'b1;
            mem_waddr = sp_rel;
            mem_wdata = a_q;
            a_d       = b_q;
          end
          OPC_LDNL: begin
            mem_re    = 1'b1;
            mem_raddr = a_rel;
            is_load   = 1'b1;
          end
          OPC_STNL: begin
            mem_we    = 1'b1;
            mem_waddr = a_rel;
            mem_wdata = b_q;
          end
          OPC_ADD: a_d = a_q + b_q;
          OPC_SUB: a_d = b_q - a_q;
          OPC_SHL: begin
            a_d = shamt_big ? '0 : b_q << a_q[$clog2(WORD_BITS)-1:0];
          end
          OPC_SHR: begin
            a_d = shamt_big ? $signed({WORD_BITS{b_q[WORD_BITS-1]}})
                            : $signed(b_q) >>> a_q[$clog2(WORD_BITS)-1:0];
          end
          OPC_ADJ: sp_d = sp_rel;
          OPC_A2SP: begin
            sp_d = a_q[ADDR_BITS-1:0];
            a_d  = b_q;
          end
          OPC_SP2A: begin
            b_d = a_q;
            a_d = WORD_BITS'(sp_q);
          end
          OPC_CALL: begin
            b_d   = a_q;
            a_d   = WORD_BITS'(pc_q);
            pc_nx = pc_rel + ADDR_BITS'(1);
          end
          OPC_RET: begin
            pc_nx = a_q[ADDR_BITS-1:0] + ADDR_BITS'(1);
            a_d   = b_q;
          end
          OPC_BRZ: begin
            if (a_q == '0) begin
              pc_nx = pc_rel + ADDR_BITS'(1);
            end
          end
          OPC_BRLZ: begin
            if (a_q[WORD_BITS-1]) begin
              pc_nx = pc_rel + ADDR_BITS'(1);
            end
          end
          OPC_BR: pc_nx = pc_rel + ADDR_BITS'(1);
          OPC_HALT: begin
            is_stop = 1'b1;
            status  = ST_HALTED;
          end
          default: begin
            is_stop = 1'b1;
            status  = ST_INVALID;
          end
        endcase

        if (is_stop) begin
          run_d = 1'b0;
        end else begin
          pc_d = pc_nx;
          if (steps_q >= step_limit_q) begin
            run_d  = 1'b0;
            status = ST_STEP_LIMIT;
          end
        end

        if (is_load) begin
          stat_d  = status;
          state_d = FSM_LOAD;
        end else begin
          done    = 1'b1;
          state_d = FSM_IDLE;
        end
      end

      FSM_LOAD: begin
        a_d     = mem_rdata;
        status  = stat_q;
        done    = 1'b1;
        state_d = FSM_IDLE;
      end
    endcase

    if (done) begin
      res_vld_d     = 1'b1;
      res_d.status  = status;
      res_d.pc_out  = pc_d;
      res_d.acc_a   = a_d;
      res_d.acc_b   = b_d;
      res_d.sp_out  = sp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_CLEAR;
      clr_q     <= '0;
      pc_q      <= PC_START;
      sp_q      <= '0;
      a_q       <= '0;
      b_q       <= '0;
      steps_q   <= '0;
      run_q     <= 1'b0;
      stat_q    <= ST_OK;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      pc_q      <= pc_d;
      sp_q      <= sp_d;
      a_q       <= a_d;
      b_q       <= b_d;
      steps_q   <= steps_d;
      run_q     <= run_d;
      stat_q    <= stat_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_end_q    <= PROG_END_RST;
      stack_start_q <= STACK_START_RST;
      step_limit_q  <= STEP_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROGRAM_END: prog_end_q    <= cfg_wdata_i[ADDR_BITS-1:0];
        CFG_STACK_START: stack_start_q <= cfg_wdata_i[ADDR_BITS-1:0];
        CFG_STEP_LIMIT:  step_limit_q  <= cfg_wdata_i[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o      = (state_q != FSM_IDLE);
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  `ACPU_ASSERT_IMPL(a_fetch_running, state_q == FSM_FETCH, run_q, "fetch while stopped")
  `ACPU_ASSERT_IMPL(a_clear_quiet, state_q == FSM_CLEAR, busy_o && !res_valid_o, "result during clear")
  `ACPU_ASSERT_IMPL(a_load_no_write, state_q == FSM_LOAD, !mem_we, "memory write in load cycle")
  `ACPU_ASSERT_NEXT(a_stopped_status, start_i && !busy_o && item_i.op == CMD_EXEC && !run_q, res_valid_o && res_o.status == ST_NOT_RUNNING, "stopped execute not flagged")

endmodule

/* rtl/acpu_ram.sv */
// generic ram, one write port and one read port with registered read data
// no dependencies
module acpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* bench/tb_accumulator_cpu_core_top.sv */
// self-checking bench for accumulator_cpu_core_top: directed programs, then random runs
// predicts every result word with an in-bench cpu model; needs acpu_pkg and the rtl
`timescale 1ns / 1ps

module tb_accumulator_cpu_core_top;
  import acpu_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  acpu_in_t                 item_i = '0;
  logic                     busy_o;
  logic                     res_valid_o;
  acpu_out_t                res_o;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i = CFG_PROGRAM_END;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i = '0;

  accumulator_cpu_core_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .item_i      (item_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // cpu model state
  logic [WORD_BITS-1:0] shadow_mem [MEM_WORDS];
  logic [WORD_BITS-1:0] acc_a_q, acc_b_q;
  logic [ADDR_BITS-1:0] pc_q, sp_q;
  logic [STEP_BITS-1:0] step_cnt;
  logic                 is_running;
  logic [ADDR_BITS-1:0] prog_end_cfg, stack_start_cfg;
  logic [STEP_BITS-1:0] step_limit_cfg;

  acpu_out_t core_state_q[$];
  int        mismatch_cnt = 0;
  int        words_sent = 0;
  int        sender_idle_pct = 35;
  int        quiet_cycles = 0;

  function automatic status_e run_instruction();
    logic [WORD_BITS-1:0] iw, arg32;
    logic [7:0]           opc;
    logic [ADDR_BITS-1:0] ofs, ea;
    logic signed [31:0]   b_signed;
    if (pc_q > prog_end_cfg) begin
      is_running = 1'b0;
      return ST_PAST_END;
    end
    step_cnt = step_cnt + STEP_BITS'(1);
    iw       = shadow_mem[pc_q];
    opc      = iw[7:0];
    arg32    = {{8{iw[31]}}, iw[31:8]};
    ofs      = iw[8 +: ADDR_BITS];
    b_signed = acc_b_q;
    case (opc)
      OPC_LDC: begin
        acc_b_q = acc_a_q;
        acc_a_q = arg32;
      end
      OPC_ADC: acc_a_q = acc_a_q + arg32;
      OPC_LDL: begin
        ea      = sp_q + ofs;
        acc_b_q = acc_a_q;
        acc_a_q = shadow_mem[ea];
      end
      OPC_STL: begin
        ea             = sp_q + ofs;
        shadow_mem[ea] = acc_a_q;
        acc_a_q        = acc_b_q;
      end
      OPC_LDNL: begin
        ea      = acc_a_q[ADDR_BITS-1:0] + ofs;
        acc_a_q = shadow_mem[ea];
      end
      OPC_STNL: begin
        ea             = acc_a_q[ADDR_BITS-1:0] + ofs;
        shadow_mem[ea] = acc_b_q;
      end
      OPC_ADD: acc_a_q = acc_a_q + acc_b_q;
      OPC_SUB: acc_a_q = acc_b_q - acc_a_q;
      OPC_SHL: begin
        if (acc_a_q >= WORD_BITS) acc_a_q = '0;
        else acc_a_q = acc_b_q << acc_a_q[4:0];
      end
      OPC_SHR: begin
        if (acc_a_q >= WORD_BITS) acc_a_q = {WORD_BITS{acc_b_q[31]}};
        else acc_a_q = b_signed >>> acc_a_q[4:0];
      end
      OPC_ADJ: sp_q = sp_q + ofs;
      OPC_A2SP: begin
        sp_q    = acc_a_q[ADDR_BITS-1:0];
        acc_a_q = acc_b_q;
      end
      OPC_SP2A: begin
        acc_b_q = acc_a_q;
        acc_a_q = WORD_BITS'(sp_q);
      end
      OPC_CALL: begin
        acc_b_q = acc_a_q;
        acc_a_q = WORD_BITS'(pc_q);
        pc_q    = pc_q + ofs;
      end
      OPC_RET: begin
        pc_q    = acc_a_q[ADDR_BITS-1:0];
        acc_a_q = acc_b_q;
      end
      OPC_BRZ: if (acc_a_q == '0) pc_q = pc_q + ofs;
      OPC_BRLZ: if (acc_a_q[31]) pc_q = pc_q + ofs;
      OPC_BR: pc_q = pc_q + ofs;
      OPC_HALT: begin
        is_running = 1'b0;
        return ST_HALTED;
      end
      default: begin
        is_running = 1'b0;
        return ST_INVALID;
      end
    endcase
    pc_q = pc_q + ADDR_BITS'(1);
    if (step_cnt >= step_limit_cfg) begin
      is_running = 1'b0;
      return ST_STEP_LIMIT;
    end
    return ST_OK;
  endfunction

  function automatic acpu_out_t advance_core(acpu_in_t w);
    acpu_out_t r;
    r.status = ST_OK;
    case (w.op)
      CMD_WRITE: shadow_mem[w.address] = w.data;
      CMD_START: begin
        pc_q       = PC_START;
        sp_q       = stack_start_cfg;
        acc_a_q    = '0;
        acc_b_q    = '0;
        step_cnt   = '0;
        is_running = 1'b1;
      end
      CMD_EXEC: begin
        if (is_running) r.status = run_instruction();
        else r.status = ST_NOT_RUNNING;
      end
      default: ;
    endcase
    r.pc_out = pc_q;
    r.acc_a  = acc_a_q;
    r.acc_b  = acc_b_q;
    r.sp_out = sp_q;
    return r;
  endfunction

  function automatic logic [WORD_BITS-1:0] encode_instr(logic [7:0] opc, logic [23:0] arg);
    return {arg, opc};
  endfunction

  function automatic logic [WORD_BITS-1:0] random_instruction();
    logic [7:0]  opc;
    logic [23:0] arg;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 4) opc = 8'($urandom_range(OPC_HALT + 1, 255));
    else if (pick < 9) opc = OPC_HALT;
    else opc = 8'($urandom_range(OPC_LDC, OPC_BR));
    pick = $urandom_range(99);
    if (pick < 60) arg = 24'(int'($urandom_range(12)) - 6);
    else if (pick < 72) arg = 24'($urandom_range(28, 36));
    else if (pick < 80) arg = $urandom_range(1) ? 24'h800000 : 24'h7FFFFF;
    else arg = 24'($urandom);
    return encode_instr(opc, arg);
  endfunction

  function automatic logic [WORD_BITS-1:0] random_data();
    case ($urandom_range(5))
      0, 1: return WORD_BITS'($urandom_range(40));
      2: return WORD_BITS'(-int'($urandom_range(1, 40)));
      3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic void note_mismatch(string what);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endfunction

  function automatic void check_field(string nm, logic [31:0] want, logic [31:0] got);
    if (got !== want)
      note_mismatch($sformatf("%s expected %h got %h", nm, want, got));
  endfunction

  // result word checker
  always @(posedge clk_i) begin : res_checker
    acpu_out_t want;
    if (rst_ni && res_valid_o) begin
      if (core_state_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result word %h", res_o));
      end else begin
        want = core_state_q.pop_front();
        check_field("status", 32'(want.status), 32'(res_o.status));
        check_field("pc_out", 32'(want.pc_out), 32'(res_o.pc_out));
        check_field("acc_a", want.acc_a, res_o.acc_a);
        check_field("acc_b", want.acc_b, res_o.acc_b);
        check_field("sp_out", 32'(want.sp_out), 32'(res_o.sp_out));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_word(input acpu_in_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    core_state_q = {core_state_q, advance_core(w)};
    words_sent++;
  endtask

  task automatic put_word(input logic [ADDR_BITS-1:0] addr, input logic [WORD_BITS-1:0] d);
    acpu_in_t w;
    w.op      = CMD_WRITE;
    w.address = addr;
    w.data    = d;
    send_word(w);
  endtask

  task automatic send_op(input cmd_e c);
    acpu_in_t w;
    w.op      = c;
    w.address = ADDR_BITS'($urandom);
    w.data    = $urandom;
    send_word(w);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (core_state_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_PROGRAM_END: prog_end_cfg = val[ADDR_BITS-1:0];
      CFG_STACK_START: stack_start_cfg = val[ADDR_BITS-1:0];
      CFG_STEP_LIMIT: step_limit_cfg = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic randomize_config();
    logic [CFG_DATA_BITS-1:0] v;
    wait_idle();
    case ($urandom_range(9))
      0: v = '0;
      1, 2, 3: v = CFG_DATA_BITS'(MEM_WORDS - 1);
      default: v = CFG_DATA_BITS'($urandom_range(4, 40));
    endcase
    cfg_write(CFG_PROGRAM_END, v);
    case ($urandom_range(5))
      0: v = '0;
      1: v = CFG_DATA_BITS'(MEM_WORDS - 1);
      default: v = CFG_DATA_BITS'($urandom_range(MEM_WORDS - 1));
    endcase
    cfg_write(CFG_STACK_START, v);
    case ($urandom_range(9))
      0: v = CFG_DATA_BITS'(1);
      1: v = {CFG_DATA_BITS{1'b1}};
      2: v = '0;
      3: v = CFG_DATA_BITS'($urandom_range(1, 24'hFFFFFF));
      default: v = CFG_DATA_BITS'($urandom_range(2, 48));
    endcase
    cfg_write(CFG_STEP_LIMIT, v);
  endtask

  task automatic random_program_run();
    int n_instr, n_steps, i;
    n_instr = $urandom_range(2, 14);
    for (i = 1; i <= n_instr; i++) put_word(ADDR_BITS'(i), random_instruction());
    repeat ($urandom_range(2))
      put_word(stack_start_cfg + ADDR_BITS'($urandom_range(7)), random_data());
    if ($urandom_range(11) != 0) send_op(CMD_START);
    n_steps = $urandom_range(3, 40);
    while (n_steps > 0 && is_running) begin
      case ($urandom_range(39))
        0: put_word(ADDR_BITS'($urandom), random_data());
        1: send_op(CMD_NONE);
        default: send_op(CMD_EXEC);
      endcase
      n_steps--;
    end
    if ($urandom_range(2) == 0) send_op(CMD_EXEC);
  endtask

  // default registers: stopped core, no-op word, start, then past program end
  task automatic test_after_reset();
    send_op(CMD_EXEC);
    send_op(CMD_NONE);
    send_op(CMD_START);
    send_op(CMD_EXEC);
  endtask

  // address and pc wrap, word extremes, shift sign fill, invalid opcode
  task automatic test_wrap_and_faults();
    wait_idle();
    cfg_write(CFG_PROGRAM_END, CFG_DATA_BITS'(MEM_WORDS - 1));
    cfg_write(CFG_STACK_START, CFG_DATA_BITS'(MEM_WORDS - 1));
    cfg_write(CFG_STEP_LIMIT, {CFG_DATA_BITS{1'b1}});
    put_word('0, 32'h8000_0000);
    put_word(ADDR_BITS'(MEM_WORDS - 1), 32'h7FFF_FFFF);
    put_word(10'd1, encode_instr(OPC_LDL, 24'd1));
    put_word(10'd2, encode_instr(OPC_LDC, 24'h800000));
    put_word(10'd3, encode_instr(OPC_SHR, '0));
    put_word(10'd4, encode_instr(OPC_BR, 24'(-6)));
    send_op(CMD_START);
    repeat (6) send_op(CMD_EXEC);
  endtask

  // zero step limit stops after one instruction; halt ignores the limit
  task automatic test_step_limit();
    wait_idle();
    cfg_write(CFG_STEP_LIMIT, '0);
    put_word(10'd1, encode_instr(OPC_LDC, 24'h7FFFFF));
    send_op(CMD_START);
    send_op(CMD_EXEC);
    wait_idle();
    cfg_write(CFG_STEP_LIMIT, 24'd2);
    put_word(10'd2, encode_instr(OPC_HALT, '0));
    send_op(CMD_START);
    send_op(CMD_EXEC);
    send_op(CMD_EXEC);
  endtask

  task automatic test_random_programs(input int idle_pct, input int last_word);
    sender_idle_pct = idle_pct;
    randomize_config();
    while (words_sent < last_word) begin
      if ($urandom_range(5) == 0) randomize_config();
      random_program_run();
    end
  endtask

  initial begin
    for (int i = 0; i < MEM_WORDS; i++) shadow_mem[i] = '0;
    acc_a_q         = '0;
    acc_b_q         = '0;
    pc_q            = PC_START;
    sp_q            = '0;
    step_cnt        = '0;
    is_running      = 1'b0;
    prog_end_cfg    = PROG_END_RST;
    stack_start_cfg = STACK_START_RST;
    step_limit_cfg  = STEP_LIMIT_RST;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_after_reset();
    test_wrap_and_faults();
    test_step_limit();
    test_random_programs(35, 500);
    test_random_programs(87, 975);
    test_random_programs(0, 1450);

    wait_idle();
    if (mismatch_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
